/* src/hop_by_hop_header_filter_core_assert.svh */
// Assertion macros used by the checker file of the header filter.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef HOP_BY_HOP_HEADER_FILTER_CORE_ASSERT_SVH
`define HOP_BY_HOP_HEADER_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define HBH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("hop-by-hop filter: implication check failed");

// Next-cycle implication, checked out of reset.
`define HBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("hop-by-hop filter: next-cycle check failed");

`endif

/* src/hbh_pkg.sv */
// Shared types, constants and key tables of the hop-by-hop header filter.
// Used by the controller, the datapath and the top level.
package hbh_pkg;

	localparam int ByteW       = 8;
	localparam int CtrW        = 5;
	localparam int HeadDepth   = 17;
	localparam int KeyPlainLen = 11;
	localparam int KeyProxyLen = 17;
	localparam int TrailerLen  = 21;

	localparam logic [ByteW-1:0] ChCr = 8'd13;
	localparam logic [ByteW-1:0] ChLf = 8'd10;

	typedef enum logic [1:0] {
		PH_REQ,
		PH_HDR,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		DEC_UNDEC,
		DEC_PASS,
		DEC_DROP
	} decided_t;

	typedef enum logic [2:0] {
		SRC_CONT,
		SRC_HEAD,
		SRC_CR,
		SRC_LF,
		SRC_TRAIL
	} emit_src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CONT_CR,
		ST_FLUSH_CR,
		ST_BYTE,
		ST_CONT_B,
		ST_FLUSH_B,
		ST_LE,
		ST_LE_FLUSH,
		ST_LE_CR,
		ST_LE_LF,
		ST_TRAIL
	} state_t;

	typedef struct packed {
		logic      latch;
		logic      ph0_step;
		logic      clr_held;
		logic      set_held;
		logic      cont_go;
		logic      cont_cr;
		logic      emit;
		emit_src_t src;
		logic      new_line;
		logic      trail_done;
	} hbh_cmd_t;

	typedef struct packed {
		phase_t   phase;
		logic     held_cr;
		logic     byte_is_lf;
		logic     byte_is_cr;
		logic     last;
		decided_t decided;
		logic     count_zero;
		logic     cont_emit;
		logic     cont_flush;
		logic     out_free;
		logic     head_end;
		logic     trail_end;
	} hbh_status_t;

	function automatic logic [ByteW-1:0] fold(input logic [ByteW-1:0] c);
		logic [ByteW-1:0] r;
		r = c;
		if (c >= "A" && c <= "Z")
			r = c + 8'd32;
		return r;
	endfunction

	// Keys stored already folded to lower case.
	function automatic logic [ByteW-1:0] key_plain(input logic [CtrW-1:0] i);
		logic [ByteW-1:0] k;
		case (i)
			5'd0:    k = "c";
			5'd1:    k = "o";
			5'd2:    k = "n";
			5'd3:    k = "n";
			5'd4:    k = "e";
			5'd5:    k = "c";
			5'd6:    k = "t";
			5'd7:    k = "i";
			5'd8:    k = "o";
			5'd9:    k = "n";
			5'd10:   k = ":";
			default: k = 8'h00;
		endcase
		return k;
	endfunction

	function automatic logic [ByteW-1:0] key_proxy(input logic [CtrW-1:0] i);
		logic [ByteW-1:0] k;
		case (i)
			5'd0:    k = "p";
			5'd1:    k = "r";
			5'd2:    k = "o";
			5'd3:    k = "x";
			5'd4:    k = "y";
			5'd5:    k = "-";
			5'd6:    k = "c";
			5'd7:    k = "o";
			5'd8:    k = "n";
			5'd9:    k = "n";
			5'd10:   k = "e";
			5'd11:   k = "c";
			5'd12:   k = "t";
			5'd13:   k = "i";
			5'd14:   k = "o";
			5'd15:   k = "n";
			5'd16:   k = ":";
			default: k = 8'h00;
		endcase
		return k;
	endfunction

	function automatic logic [ByteW-1:0] trailer_char(input logic [CtrW-1:0] i);
		logic [ByteW-1:0] k;
		case (i)
			5'd0:    k = "C";
			5'd1:    k = "o";
			5'd2:    k = "n";
			5'd3:    k = "n";
			5'd4:    k = "e";
			5'd5:    k = "c";
			5'd6:    k = "t";
			5'd7:    k = "i";
			5'd8:    k = "o";
			5'd9:    k = "n";
			5'd10:   k = ":";
			5'd11:   k = " ";
			5'd12:   k = "c";
			5'd13:   k = "l";
			5'd14:   k = "o";
			5'd15:   k = "s";
			5'd16:   k = "e";
			5'd17:   k = ChCr;
			5'd18:   k = ChLf;
			5'd19:   k = ChCr;
			5'd20:   k = ChLf;
			default: k = 8'h00;
		endcase
		return k;
	endfunction

endpackage

/* src/hbh_ctrl.sv */
// Sequencing state machine of the hop-by-hop header filter.
// Depends on hbh_pkg; drives the datapath by command struct only.
module hbh_ctrl import hbh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  hbh_status_t st,
	output hbh_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid)
					state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				case (st.phase)
					PH_REQ: state_d = st.last ? ST_TRAIL : ST_IDLE;
					PH_HDR: begin
						if (st.held_cr) begin
							if (st.byte_is_lf)
								state_d = (st.decided == DEC_UNDEC && st.count_zero) ?
									ST_TRAIL : ST_LE;
							else
								state_d = ST_CONT_CR;
						end else begin
							state_d = ST_BYTE;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_CONT_CR: begin
				if (st.decided == DEC_DROP)
					state_d = ST_BYTE;
				else if (st.cont_emit) begin
					if (st.out_free)
						state_d = ST_BYTE;
				end else
					state_d = st.cont_flush ? ST_FLUSH_CR : ST_BYTE;
			end
			ST_FLUSH_CR: begin
				if (st.out_free && st.head_end)
					state_d = ST_BYTE;
			end
			ST_BYTE: begin
				if (st.byte_is_cr && !st.last)
					state_d = ST_IDLE;
				else
					state_d = ST_CONT_B;
			end
			ST_CONT_B: begin
				if (st.decided == DEC_DROP)
					state_d = st.last ? ST_LE : ST_IDLE;
				else if (st.cont_emit) begin
					if (st.out_free)
						state_d = st.last ? ST_LE : ST_IDLE;
				end else if (st.cont_flush)
					state_d = ST_FLUSH_B;
				else
					state_d = st.last ? ST_LE : ST_IDLE;
			end
			ST_FLUSH_B: begin
				if (st.out_free && st.head_end)
					state_d = st.last ? ST_LE : ST_IDLE;
			end
			ST_LE: begin
				if (st.decided == DEC_DROP)
					state_d = st.last ? ST_TRAIL : ST_IDLE;
				else if (st.decided == DEC_UNDEC && !st.count_zero)
					state_d = ST_LE_FLUSH;
				else
					state_d = ST_LE_CR;
			end
			ST_LE_FLUSH: begin
				if (st.out_free && st.head_end)
					state_d = ST_LE_CR;
			end
			ST_LE_CR: begin
				if (st.out_free)
					state_d = ST_LE_LF;
			end
			ST_LE_LF: begin
				if (st.out_free)
					state_d = st.last ? ST_TRAIL : ST_IDLE;
			end
			ST_TRAIL: begin
				if (st.out_free && st.trail_end)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands. cont_cr follows the state alone.
	always_comb begin
		cmd      = '0;
		cmd.src  = SRC_CONT;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
			end
			ST_DISPATCH: begin
				if (st.phase == PH_REQ)
					cmd.ph0_step = 1'b1;
				else if (st.phase == PH_HDR && st.held_cr)
					cmd.clr_held = 1'b1;
			end
			ST_CONT_CR, ST_CONT_B: begin
				cmd.cont_cr = (state_q == ST_CONT_CR);
				if (st.decided != DEC_DROP && st.cont_emit) begin
					cmd.cont_go = st.out_free;
					cmd.emit    = st.out_free;
				end else begin
					cmd.cont_go = 1'b1;
				end
			end
			ST_FLUSH_CR, ST_FLUSH_B, ST_LE_FLUSH: begin
				cmd.src  = SRC_HEAD;
				cmd.emit = st.out_free;
			end
			ST_BYTE: begin
				cmd.set_held = st.byte_is_cr && !st.last;
			end
			ST_LE: begin
				cmd.new_line = (st.decided == DEC_DROP);
			end
			ST_LE_CR: begin
				cmd.src  = SRC_CR;
				cmd.emit = st.out_free;
			end
			ST_LE_LF: begin
				cmd.src      = SRC_LF;
				cmd.emit     = st.out_free;
				cmd.new_line = st.out_free;
			end
			ST_TRAIL: begin
				cmd.src        = SRC_TRAIL;
				cmd.emit       = st.out_free;
				cmd.trail_done = st.out_free && st.trail_end;
			end
			default: begin
				cmd.src = SRC_CONT;
			end
		endcase
	end

endmodule

/* src/hbh_dpath.sv */
// Datapath of the hop-by-hop header filter: line state, head store,
// key compare, word counter and output register. Depends on hbh_pkg.
module hbh_dpath import hbh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [ByteW-1:0] in_byte,
	input  logic             in_last,
	input  hbh_cmd_t         cmd,
	output hbh_status_t      st,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [ByteW-1:0] out_byte,
	output logic             out_last
);

	logic [ByteW-1:0] byte_q;
	logic             last_q;
	logic [ByteW-1:0] head_q [HeadDepth];
	phase_t           phase_q;
	logic             held_cr_q;
	logic [CtrW-1:0]  count_q;
	logic             mplain_q;
	logic             mproxy_q;
	decided_t         dec_q;
	logic [CtrW-1:0]  ctr_q;
	logic             out_valid_q;
	logic [ByteW-1:0] out_byte_q;
	logic             out_last_q;

	logic [ByteW-1:0] x;
	logic [ByteW-1:0] x_fold;
	logic             head_full;
	logic             plain_new;
	logic             proxy_new;
	logic [CtrW-1:0]  count_inc;
	logic             cont_emit;
	logic             out_free;
	logic             head_end;
	logic             trail_end;
	logic [ByteW-1:0] emit_byte;
	logic             emit_last;

	assign x         = cmd.cont_cr ? ChCr : byte_q;
	assign x_fold    = fold(x);
	assign head_full = (count_q >= CtrW'(HeadDepth));
	assign plain_new = mplain_q &&
		((count_q >= CtrW'(KeyPlainLen)) || (x_fold == key_plain(count_q)));
	assign proxy_new = mproxy_q && (x_fold == key_proxy(count_q));
	assign count_inc = count_q + CtrW'(1);
	assign cont_emit = (dec_q == DEC_PASS) || head_full;
	assign out_free  = !out_valid_q || out_ready;
	assign head_end  = ((ctr_q + CtrW'(1)) == count_q);
	assign trail_end = (ctr_q == CtrW'(TrailerLen - 1));

	always_comb begin
		emit_byte = x;
		emit_last = 1'b0;
		case (cmd.src)
			SRC_CONT:  emit_byte = x;
			SRC_HEAD:  emit_byte = head_q[ctr_q];
			SRC_CR:    emit_byte = ChCr;
			SRC_LF:    emit_byte = ChLf;
			SRC_TRAIL: begin
				emit_byte = trailer_char(ctr_q);
				emit_last = trail_end;
			end
			default:   emit_byte = x;
		endcase
	end

	// Payload registers: input word, the held line head and the output word.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			byte_q <= in_byte;
			last_q <= in_last;
		end
		if (cmd.cont_go && dec_q == DEC_UNDEC && !head_full)
			head_q[count_q] <= x;
		if (cmd.emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_REQ;
			held_cr_q   <= 1'b0;
			count_q     <= '0;
			mplain_q    <= 1'b1;
			mproxy_q    <= 1'b1;
			dec_q       <= DEC_UNDEC;
			ctr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.ph0_step) begin
				if (held_cr_q && byte_q == ChLf) begin
					phase_q   <= PH_HDR;
					held_cr_q <= 1'b0;
					count_q   <= '0;
					mplain_q  <= 1'b1;
					mproxy_q  <= 1'b1;
					dec_q     <= DEC_UNDEC;
				end else begin
					held_cr_q <= (byte_q == ChCr);
				end
			end
			if (cmd.clr_held)
				held_cr_q <= 1'b0;
			if (cmd.set_held)
				held_cr_q <= 1'b1;
			// Content: drop, pass straight through, or grow the head.
			if (cmd.cont_go && dec_q != DEC_DROP) begin
				if (cont_emit) begin
					dec_q <= DEC_PASS;
				end else begin
					mplain_q <= plain_new;
					mproxy_q <= proxy_new;
					count_q  <= count_inc;
					if (count_inc == CtrW'(KeyPlainLen) && plain_new)
						dec_q <= DEC_DROP;
					else if (count_inc == CtrW'(KeyProxyLen))
						dec_q <= proxy_new ? DEC_DROP : DEC_PASS;
				end
			end
			if (cmd.new_line) begin
				count_q  <= '0;
				mplain_q <= 1'b1;
				mproxy_q <= 1'b1;
				dec_q    <= DEC_UNDEC;
			end
			if (cmd.trail_done) begin
				phase_q   <= PH_DONE;
				held_cr_q <= 1'b0;
			end
			// Word counter walks the head on a flush and the trailer text.
			if (cmd.emit && cmd.src == SRC_HEAD)
				ctr_q <= head_end ? '0 : ctr_q + CtrW'(1);
			else if (cmd.emit && cmd.src == SRC_TRAIL)
				ctr_q <= trail_end ? '0 : ctr_q + CtrW'(1);
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		st            = '0;
		st.phase      = phase_q;
		st.held_cr    = held_cr_q;
		st.byte_is_lf = (byte_q == ChLf);
		st.byte_is_cr = (byte_q == ChCr);
		st.last       = last_q;
		st.decided    = dec_q;
		st.count_zero = (count_q == '0);
		st.cont_emit  = cont_emit;
		st.cont_flush = (dec_q == DEC_UNDEC) && !head_full &&
			(count_inc == CtrW'(KeyProxyLen)) && !proxy_new;
		st.out_free   = out_free;
		st.head_end   = head_end;
		st.trail_end  = trail_end;
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

/* src/hop_by_hop_header_filter_core.sv */
// Hop-by-hop header filter, top level: strips the request line and any
// "Connection:" or "Proxy-Connection:" header line from a received HTTP
// header block (compared without regard to letter case on up to 17 head
// bytes of each line), passes all other lines on with CR LF, and closes the
// stream with "Connection: close" CR LF CR LF, the last word of which carries
// m_axis_tlast. The trailer goes out at the empty line or at the word flagged
// by s_axis_tlast, whichever comes first; an unfinished final line that is
// kept is flushed whole with CR LF before it, and every later input word
// is taken and dropped. Words are handled one at a time by a sequencer: a
// new input word is taken only once the last one is through its content,
// flush, line end and trailer steps. A line end emits CR LF, after the
// held head bytes when the line is still undecided, and nothing for a
// dropped line. A line that reaches its 17th head byte undecided and is no
// Proxy-Connection line flushes its head, and the trailer emits its 21
// words. Every emitting step waits while the output register stays full.
// The output register lets the last result wait on m_axis_tready while
// the next input word is already taken.
// Depends on hbh_pkg (types, key tables) and the hbh_ctrl / hbh_dpath pair.
module hop_by_hop_header_filter_core import hbh_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	// in_byte
	input  logic [ByteW-1:0] s_axis_tdata,
	input  logic             s_axis_tlast,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// out_byte
	output logic [ByteW-1:0] m_axis_tdata,
	output logic             m_axis_tlast,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready
);

	hbh_cmd_t    cmd;
	hbh_status_t st;

	// Controller: walks each input word through content, flush, line end
	// and trailer steps; emitting steps advance only when the output register is free.
	hbh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// Datapath: hold the line head, compare against both keys, drive the
	// output register.
	hbh_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.cmd       (cmd),
		.st        (st),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

/* src/hbh_checker.sv */
// Port-level checks of the hop-by-hop header filter, bound to the top level.
// Depends on hop_by_hop_header_filter_core_assert.svh and hbh_pkg.
`include "hop_by_hop_header_filter_core_assert.svh"

module hbh_checker import hbh_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic [ByteW-1:0] m_axis_tdata,
	input logic             m_axis_tlast,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready
);

	logic in_take;
	logic out_take;

	assign in_take  = s_axis_tvalid && s_axis_tready;
	assign out_take = m_axis_tvalid && m_axis_tready;

	// A stalled output word holds.
	`HBH_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// One word at a time: the sequencer is busy right after a take.
	`HBH_ASSERT_NEXT(a_in_one_at_a_time, clk, arst_n, in_take, !s_axis_tready)

	// Nothing follows the closing word of the trailer.
	`HBH_ASSERT_NEXT(a_quiet_after_close, clk, arst_n, out_take && m_axis_tlast, !m_axis_tvalid)

	// The closing word is always the LF of the trailer.
	`HBH_ASSERT_IMPL(a_close_is_lf, clk, arst_n, m_axis_tvalid && m_axis_tlast, m_axis_tdata == ChLf)

endmodule

bind hop_by_hop_header_filter_core hbh_checker u_hbh_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);
